// File: design/wildcard_glob_matcher_core_defines.svh
// assertion macros shared by the wildcard glob matcher design files
// expects clk and arst_n in the scope of each use
`ifndef WILDCARD_GLOB_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define WGM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wgm assertion failed");

// next-cycle implication, held off during reset
`define WGM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wgm assertion failed");

`endif

// File: design/wgm_pkg.sv
// types, constants and the star closure function of the wildcard glob matcher
// no dependencies
package wgm_pkg;

	localparam int unsigned PATTERN_MAX = 64;
	localparam int unsigned POS_W = $clog2(PATTERN_MAX + 1);
	localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int unsigned LIVE_W = PATTERN_MAX + 1;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] QUERY_BYTE = 8'h3F;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_SUBJECT = 2'd2;
	localparam logic [1:0] ACT_END = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} result_t;

	typedef logic [PATTERN_MAX-1:0] pos_vec_t;
	typedef logic [LIVE_W-1:0] live_t;
	typedef logic [PATTERN_MAX-1:0][7:0] pat_bytes_t;

	// pattern view, star and query already limited to used positions
	typedef struct packed {
		pos_vec_t star;
		pos_vec_t query;
		pos_vec_t used;
		logic [POS_W-1:0] length;
		logic overflow;
	} pat_view_t;

	// a live star makes the next position live, along whole runs of stars:
	// a live star starts a carry that ripples through the run
	function automatic live_t close_stars(live_t seed, pos_vec_t star);
		live_t s;
		live_t t;
		live_t c;
		s = {1'b0, star};
		t = seed & s;
		c = (s + t) ^ s ^ t;
		return seed | c;
	endfunction

endpackage

// File: design/wgm_pattern.sv
// pattern store: bytes, star and query flags, length and overflow
// depends on wgm_pkg
module wgm_pattern
	import wgm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  item_t      item,
	output pat_view_t  cur,
	output pos_vec_t   nxt_star,
	output pat_bytes_t bytes
);

	pos_vec_t star_q;
	pos_vec_t query_q;
	pos_vec_t used_q;
	pos_vec_t used_d;
	pos_vec_t star_raw;
	pos_vec_t wr_sel;
	pat_bytes_t bytes_q;
	logic [POS_W-1:0] length_q;
	logic [POS_W-1:0] length_d;
	logic overflow_q;
	logic overflow_d;
	logic full;
	logic wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic is_star;
	logic is_query;

	assign full = (length_q == POS_W'(PATTERN_MAX));
	assign wr_idx = length_q[IDX_W-1:0];
	assign wr_sel = pos_vec_t'(1) << wr_idx;
	assign is_star = (item.data_byte == STAR_BYTE);
	assign is_query = (item.data_byte == QUERY_BYTE);
	assign wr_en = fire && (item.action == ACT_APPEND) && !full;

	always_comb begin
		used_d = used_q;
		length_d = length_q;
		overflow_d = overflow_q;
		if (fire) begin
			unique case (item.action)
				ACT_CLEAR: begin
					used_d = '0;
					length_d = '0;
					overflow_d = 1'b0;
				end
				ACT_APPEND: begin
					if (!full) begin
						used_d = used_q | wr_sel;
						length_d = length_q + POS_W'(1);
					end else begin
						overflow_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// star mask as it stands after this beat, for the restart closure
	assign star_raw = wr_en ? ((star_q & ~wr_sel) | (wr_sel & {PATTERN_MAX{is_star}})) : star_q;
	assign nxt_star = star_raw & used_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			length_q <= '0;
			overflow_q <= 1'b0;
		end else begin
			used_q <= used_d;
			length_q <= length_d;
			overflow_q <= overflow_d;
		end
	end

	// entries above the length are masked, so no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			bytes_q[wr_idx] <= item.data_byte;
			star_q[wr_idx] <= is_star;
			query_q[wr_idx] <= is_query;
		end
	end

	assign cur.star = star_q & used_q;
	assign cur.query = query_q & used_q;
	assign cur.used = used_q;
	assign cur.length = length_q;
	assign cur.overflow = overflow_q;
	assign bytes = bytes_q;

endmodule

// File: design/wgm_nfa.sv
// live position set of the matcher automaton and the end-of-subject verdict
// depends on wgm_pkg
module wgm_nfa
	import wgm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  item_t      item,
	input  pat_view_t  cur,
	input  pos_vec_t   nxt_star,
	input  pat_bytes_t bytes,
	output result_t    verdict
);

	live_t live_q;
	live_t live_d;
	live_t step;
	pos_vec_t lit;

	// literal or query position that takes this subject byte
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			lit[i] = cur.used[i] && !cur.star[i] &&
				(cur.query[i] || (bytes[i] == item.data_byte));
		end
	end

	// stars keep themselves, literals advance one place
	assign step = {1'b0, live_q[PATTERN_MAX-1:0] & cur.star} |
		{live_q[PATTERN_MAX-1:0] & lit, 1'b0};

	always_comb begin
		if (item.action == ACT_SUBJECT) begin
			live_d = close_stars(step, cur.star);
		end else begin
			live_d = close_stars(LIVE_W'(1), nxt_star);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= LIVE_W'(1);
		end else if (fire) begin
			live_q <= live_d;
		end
	end

	assign verdict.matched = live_q[cur.length] && !cur.overflow;
	assign verdict.pattern_overflow = cur.overflow;

endmodule

// File: design/wildcard_glob_matcher_core.sv
// top level of the wildcard glob matcher: input stage, pattern store, automaton, result register
// depends on wgm_pkg, wgm_pattern, wgm_nfa and wildcard_glob_matcher_core_defines.svh
//
// usage
//   item channel (item_valid / item_ready / item) carries one command beat:
//   clear pattern, append pattern byte, subject byte or end of subject
//   result channel (result_valid / result_ready / result) carries one beat
//   per end of subject: matched and the sticky pattern_overflow flag
//   star matches any run of bytes, question mark any one byte
//   throughput: one item beat per cycle, except that an end beat holds while a
//   result waits; the automaton updates all live pattern positions together
//   result path: an end beat waits in the input stage, and when it is applied
//   the verdict comes straight off the live set into the result register,
//   which then drives the result beat
//   stall: while result_ready is low and a result waits, clear, append and
//   subject beats still flow; only a further end beat holds in the input
//   stage, and item_ready drops once that stage cannot drain
//   reset: empty pattern, overflow clear, only position zero live, both
//   channels empty; no clearing pass, the block takes beats right away
`include "wildcard_glob_matcher_core_defines.svh"

module wildcard_glob_matcher_core
	import wgm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// input stage
	logic valid_s1;
	item_t item_s1;
	// s1 beat is applied to the state this cycle
	logic adv;
	logic end_beat;

	// result register
	logic result_valid_q;
	result_t result_q;

	pat_view_t pat_cur;
	pos_vec_t pat_nxt_star;
	pat_bytes_t pat_bytes;
	result_t verdict;

	assign end_beat = (item_s1.action == ACT_END);
	// only an end beat needs room in the result register
	assign adv = valid_s1 && (!end_beat || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	wgm_pattern u_pattern (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (adv),
		.item     (item_s1),
		.cur      (pat_cur),
		.nxt_star (pat_nxt_star),
		.bytes    (pat_bytes)
	);

	wgm_nfa u_nfa (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (adv),
		.item     (item_s1),
		.cur      (pat_cur),
		.nxt_star (pat_nxt_star),
		.bytes    (pat_bytes),
		.verdict  (verdict)
	);

	// verdict is read from the live set before the restart lands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && end_beat) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && end_beat) begin
			result_q <= verdict;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	// a new beat only lands on a busy input stage that drains this cycle
	`WGM_ASSERT_IMP(a_s1_no_overwrite, item_valid && item_ready && valid_s1, adv)
	// an end beat never overwrites a result that is still waiting
	`WGM_ASSERT_IMP(a_result_no_overwrite, adv && end_beat,
		!result_valid_q || result_ready)
	// overflow always forces a miss
	`WGM_ASSERT_IMP(a_overflow_no_match, result_valid && result.pattern_overflow,
		!result.matched)
	// length stays within capacity and agrees with the used mask
	`WGM_ASSERT_IMP(a_length_mask, 1'b1,
		(pat_cur.length <= POS_W'(PATTERN_MAX)) &&
		($countones(pat_cur.used) == int'(pat_cur.length)))

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for wildcard_glob_matcher_core: directed corner beats, then random
// patterns and subjects checked against an in-bench star / query automaton
// depends on wgm_pkg and the wildcard_glob_matcher_core rtl

import wgm_pkg::*;

// keeps its own copy of the pattern, the live position set and the overflow flag,
// and queues the verdict each end of subject should produce
class glob_match_tracker;
	logic [7:0] pat_bytes [PATTERN_MAX];
	int unsigned pat_len;
	bit live [PATTERN_MAX+1];
	bit ovf;
	result_t expected_verdicts [$];
	int unsigned mismatches;
	int unsigned verdicts_checked;
	int unsigned hits_seen;
	int unsigned overflow_seen;

	function new();
		pat_len = 0;
		ovf = 1'b0;
		mismatches = 0;
		verdicts_checked = 0;
		hits_seen = 0;
		overflow_seen = 0;
		restart_subject();
	endfunction

	// a live star also makes the next position live, walking forward
	function void close_stars();
		for (int unsigned i = 0; i < pat_len; i++) begin
			if (live[i] && pat_bytes[i] == STAR_BYTE)
				live[i+1] = 1'b1;
		end
	endfunction

	function void restart_subject();
		foreach (live[i])
			live[i] = 1'b0;
		live[0] = 1'b1;
		close_stars();
	endfunction

	function void consume(logic [7:0] c);
		bit nxt [PATTERN_MAX+1];
		foreach (nxt[i])
			nxt[i] = 1'b0;
		for (int unsigned i = 0; i < pat_len; i++) begin
			if (live[i]) begin
				if (pat_bytes[i] == STAR_BYTE)
					nxt[i] = 1'b1;
				else if (pat_bytes[i] == QUERY_BYTE || pat_bytes[i] == c)
					nxt[i+1] = 1'b1;
			end
		end
		live = nxt;
		close_stars();
	endfunction

	function void take_item(item_t it);
		result_t want;
		case (it.action)
			ACT_CLEAR: begin
				pat_len = 0;
				ovf = 1'b0;
				restart_subject();
			end
			ACT_APPEND: begin
				if (pat_len < PATTERN_MAX) begin
					pat_bytes[pat_len] = it.data_byte;
					pat_len++;
				end else begin
					ovf = 1'b1;
				end
				restart_subject();
			end
			ACT_SUBJECT: begin
				consume(it.data_byte);
			end
			ACT_END: begin
				want.matched = live[pat_len] && !ovf;
				want.pattern_overflow = ovf;
				expected_verdicts.push_back(want);
				restart_subject();
			end
		endcase
	endfunction

	function void check_verdict(result_t got);
		result_t want;
		if (expected_verdicts.size() == 0) begin
			$error("result beat with no end of subject waiting");
			mismatches++;
			return;
		end
		want = expected_verdicts.pop_front();
		verdicts_checked++;
		if (got.matched !== want.matched) begin
			$error("matched: expected %0b, actual %0b", want.matched, got.matched);
			mismatches++;
		end
		if (got.pattern_overflow !== want.pattern_overflow) begin
			$error("pattern_overflow: expected %0b, actual %0b",
				want.pattern_overflow, got.pattern_overflow);
			mismatches++;
		end
		if (want.matched)
			hits_seen++;
		if (want.pattern_overflow)
			overflow_seen++;
	endfunction
endclass

module testbench;
	// stimulus stops once this many item beats went in; the tail runs without idling
	localparam int unsigned ITEM_TARGET = 1650;
	localparam int unsigned CALM_FROM = 1450;
	// watchdog bound for the whole run, with room for gap, stall and latency on every beat
	localparam int unsigned CYCLE_LIMIT = 400000;
	// settle time after the last expected verdict, to catch stray result beats
	localparam int unsigned DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;

	glob_match_tracker tracker = new();
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned ready_hold = 0;
	// random idling on both sides while set
	bit jitter = 1'b0;

	wildcard_glob_matcher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// both channels are observed at the edge that moves the beat; values read here are
	// the ones from before the edge, so ordering against the rtl does not matter
	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			tracker.take_item(item);
		if (arst_n && result_valid && result_ready)
			tracker.check_verdict(result);
	end

	// receiver: stalls in random bursts while jitter is on
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold--;
			result_ready <= 1'b0;
		end else if (jitter && $urandom_range(0, 9) == 0) begin
			ready_hold = $urandom_range(0, 14);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// one item beat; valid stays up across back-to-back beats and only drops for a gap
	task automatic send_item(logic [1:0] act, logic [7:0] data);
		item_t it;
		it.action = act;
		it.data_byte = data;
		if (jitter && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	// small alphabet so literals collide often, with the odd full-range byte
	function automatic logic [7:0] plain_byte();
		case ($urandom_range(0, 4))
			0: return 8'h61;
			1: return 8'h62;
			2: return 8'h00;
			3: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] glob_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return STAR_BYTE;
		if (r < 40)
			return QUERY_BYTE;
		return plain_byte();
	endfunction

	// clear, load a pattern, then a few subjects that mostly follow the pattern
	task automatic run_sequence();
		logic [7:0] pat [$];
		logic [7:0] subj [$];
		int unsigned plen;
		int unsigned r;
		r = $urandom_range(0, 99);
		// mostly short patterns; a few fill the store or run past it
		if (r < 4)
			plen = $urandom_range(PATTERN_MAX - 2, PATTERN_MAX + 4);
		else if (r < 12)
			plen = $urandom_range(9, PATTERN_MAX - 1);
		else
			plen = $urandom_range(0, 8);
		repeat (plen)
			pat.push_back(glob_byte());
		send_item(ACT_CLEAR, 8'($urandom));
		foreach (pat[i])
			send_item(ACT_APPEND, pat[i]);
		repeat ($urandom_range(1, 4)) begin
			subj.delete();
			if ($urandom_range(0, 3) != 0) begin
				// walk the stored part: star takes a short run, query any byte,
				// literal itself
				for (int i = 0; i < pat.size() && i < PATTERN_MAX; i++) begin
					if (pat[i] == STAR_BYTE)
						repeat ($urandom_range(0, 3)) subj.push_back(plain_byte());
					else if (pat[i] == QUERY_BYTE)
						subj.push_back(8'($urandom));
					else
						subj.push_back(pat[i]);
				end
				// spoil roughly half of them: extra, dropped or swapped byte
				r = $urandom_range(0, 5);
				if (r == 0)
					subj.push_back(plain_byte());
				else if (r == 1 && subj.size() != 0)
					subj.delete($urandom_range(0, subj.size() - 1));
				else if (r == 2 && subj.size() != 0)
					subj[$urandom_range(0, subj.size() - 1)] = plain_byte();
			end else begin
				repeat ($urandom_range(0, 6)) subj.push_back(plain_byte());
			end
			foreach (subj[i]) begin
				// now and then the pattern grows mid-subject, which restarts it
				if ($urandom_range(0, 99) == 0)
					send_item(ACT_APPEND, glob_byte());
				send_item(ACT_SUBJECT, subj[i]);
			end
			send_item(ACT_END, 8'($urandom));
		end
	endtask

	// unstructured beats: any action, any byte
	task automatic send_noise();
		repeat ($urandom_range(3, 12))
			send_item(2'($urandom), 8'($urandom));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		jitter = 1'b1;

		// empty pattern with empty subject matches, with a non-empty one it does not
		send_item(ACT_END, 8'h00);
		send_item(ACT_SUBJECT, 8'h00);
		send_item(ACT_END, 8'hFF);
		// stars only: empty subject matches
		send_item(ACT_APPEND, STAR_BYTE);
		send_item(ACT_APPEND, STAR_BYTE);
		send_item(ACT_END, 8'h55);
		// a lone query needs exactly one byte
		send_item(ACT_CLEAR, 8'hFF);
		send_item(ACT_APPEND, QUERY_BYTE);
		send_item(ACT_END, 8'hAA);
		send_item(ACT_SUBJECT, 8'hFF);
		send_item(ACT_END, 8'h00);
		// zero byte is an ordinary literal on both sides
		send_item(ACT_CLEAR, 8'h00);
		send_item(ACT_APPEND, 8'h00);
		send_item(ACT_APPEND, 8'hFF);
		send_item(ACT_SUBJECT, 8'h00);
		send_item(ACT_SUBJECT, 8'hFF);
		send_item(ACT_END, 8'h00);
		// append in the middle of a subject restarts it
		send_item(ACT_SUBJECT, 8'h00);
		send_item(ACT_APPEND, STAR_BYTE);
		send_item(ACT_SUBJECT, 8'h00);
		send_item(ACT_SUBJECT, 8'hFF);
		send_item(ACT_SUBJECT, 8'h01);
		send_item(ACT_END, 8'hFF);
		send_item(ACT_CLEAR, 8'h80);

		while (items_sent < ITEM_TARGET) begin
			jitter = (items_sent < CALM_FROM) && ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 9) == 0)
				send_noise();
			else
				run_sequence();
		end
		item_valid <= 1'b0;

		while (tracker.expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d item beats in, %0d verdicts checked: %0d matches, %0d under overflow",
			items_sent, tracker.verdicts_checked, tracker.hits_seen, tracker.overflow_seen);
		$display("mixed star, query and literal patterns up to past capacity, with idling");
		if (tracker.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
